// File: hw/rtl/swet_pkg.sv
// shared types, constants and the c*log2(c) table for the entropy tracker
`timescale 1ns / 1ps
package swet_pkg;

  // defaults of the top-level parameters
  localparam int ENTRIES_DEF  = 256;
  localparam int KEY_BITS_DEF = 32;

  // fixed field widths
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 9;
  localparam int WIN_W   = 9;
  localparam int ENT_W   = 20;
  localparam int DK_W    = 9;
  localparam int ST_W    = 2;

  // fixed-point format and table
  localparam int FRAC_BITS = 16;
  localparam int ROM_DEPTH = 512;
  localparam int ROM_AW    = 9;
  localparam int LW        = 29;
  localparam int SW        = 28;
  localparam int PW        = CNT_W + LW;

  localparam logic [CNT_W-1:0] ITEM_CAP = CNT_W'(256);
  localparam logic [ENT_W-1:0] ENT_MAX  = '1;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(256);

  // status bits
  localparam int STAT_FULL   = 0;
  localparam int STAT_ABSENT = 1;

  // register map
  localparam int  APB_AW          = 3;
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // last step of the sum sequence
  localparam logic [2:0] SUM_LAST = 3'd5;

  typedef logic [LW-1:0] rom_t [ROM_DEPTH];

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SUM,
    ST_MUL,
    ST_DSTART1,
    ST_DIV1,
    ST_SUB,
    ST_DSTART2,
    ST_DIV2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic decide;
    logic sum;
    logic mul;
    logic div_start;
    logic div_sel;
    logic sub;
    logic finish;
  } swet_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic sum_done;
    logic div_busy;
  } swet_st_t;

  // c*log2(c) table, log2 by repeated squaring of the mantissa
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] lg;
    int          k;
    for (int c = 0; c < ROM_DEPTH; c++) begin
      if (c < 2) begin
        r[c] = '0;
      end else begin
        k = 0;
        for (int b = 1; b < ROM_AW; b++) begin
          if ((c >> b) != 0) k = b;
        end
        y = (64'(c) << 31) >> k;
        frac = '0;
        for (int i = 0; i < 30; i++) begin
          y = (y * y) >> 31;
          if (y >= 64'h1_0000_0000) begin
            frac = frac | (64'd1 << (29 - i));
            y = y >> 1;
          end
        end
        lg = (64'(k) << 30) | frac;
        r[c] = LW'((64'(c) * lg) >> (30 - FRAC_BITS));
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/swet_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module swet_div #(
  parameter int DW = 38,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic          fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/swet_datapath.sv
// key table, weighted sum, item total and entropy arithmetic
`timescale 1ns / 1ps
module swet_datapath #(
  parameter int ENTRIES  = swet_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = swet_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swet_pkg::swet_cmd_t           cmd,
  output swet_pkg::swet_st_t            st,
  input  logic                          has_new,
  input  logic [swet_pkg::KEY_W-1:0]    new_key,
  input  logic                          has_old,
  input  logic [swet_pkg::KEY_W-1:0]    old_key,
  input  logic [swet_pkg::WIN_W-1:0]    window_size,
  output logic [swet_pkg::ENT_W-1:0]    entropy,
  output logic [swet_pkg::DK_W-1:0]     distinct_keys,
  output logic [swet_pkg::ST_W-1:0]     status
);
  import swet_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int MW = KEY_BITS + CNT_W;
  localparam rom_t ROM = build_rom();

  // table memory: key and count, count zero marks a free entry
  logic [MW-1:0]       mem [ENTRIES];
  logic [MW-1:0]       rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;

  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       scan_addr;
  logic [AW-1:0]       rd_idx;
  logic                issuing;
  logic                rd_vld;

  logic                q_has_new;
  logic                q_has_old;
  logic [KEY_BITS-1:0] q_new_key;
  logic [KEY_BITS-1:0] q_old_key;

  logic                new_hit, old_hit, free_hit;
  logic [AW-1:0]       new_idx, old_idx, free_idx;
  logic [CNT_W-1:0]    new_cnt, old_cnt;

  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_live;

  logic [SW-1:0]       wsum;
  logic [CNT_W-1:0]    total;
  logic [UW-1:0]       used;

  // decision signals
  logic                add_ok, ins, same, rem_ok;
  logic [AW-1:0]       a_idx, r_idx;
  logic [CNT_W-1:0]    a_old, a_new, r_cnt;
  logic [CNT_W-1:0]    total_dec;
  logic [UW-1:0]       used_dec;

  // registered decision
  logic                wa_en, wr_en;
  logic [AW-1:0]       wa_idx, wr_idx;
  logic [CNT_W-1:0]    wa_cnt, wr_cnt;
  logic [ROM_AW-1:0]   ta [4];
  logic [ST_W-1:0]     stat_q;

  logic [2:0]          step;
  logic [ROM_AW-1:0]   rom_addr;
  logic [LW-1:0]       rom_q;
  logic [LW-1:0]       acc;
  logic [LW-1:0]       lw_q;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       diff;
  logic                nonpos;

  logic                div_busy;
  logic [PW-1:0]       quo;

  // table read fields
  assign rd_key  = rd_data[MW-1:CNT_W];
  assign rd_cnt  = rd_data[CNT_W-1:0];
  assign rd_live = rd_cnt != '0;

  // memory write select: clearing pass, then the add and remove writes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.sum && step == 3'd0 && wa_en) begin
      mem_we    = 1'b1;
      mem_waddr = wa_idx;
      mem_wdata = {q_new_key, wa_cnt};
    end else if (cmd.sum && step == 3'd1 && wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = wr_idx;
      mem_wdata = {q_old_key, wr_cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[scan_addr];
  end

  // what the item does to the table
  always_comb begin
    add_ok    = q_has_new && (total != ITEM_CAP) && (new_hit || free_hit);
    ins       = add_ok && !new_hit;
    a_idx     = new_hit ? new_idx : free_idx;
    a_old     = new_hit ? new_cnt : '0;
    a_new     = a_old + 1'b1;
    same      = q_has_old && add_ok && (q_old_key == q_new_key);
    rem_ok    = q_has_old && (same || old_hit);
    r_idx     = same ? a_idx : old_idx;
    r_cnt     = same ? a_new : old_cnt;
    total_dec = total + CNT_W'(add_ok) - CNT_W'(rem_ok);
    used_dec  = used + UW'(ins) - UW'(rem_ok && r_cnt == CNT_W'(1));
  end

  // table address of each sum term
  always_comb begin
    case (step)
      3'd0:    rom_addr = ta[0];
      3'd1:    rom_addr = ta[1];
      3'd2:    rom_addr = ta[2];
      3'd3:    rom_addr = ta[3];
      3'd4:    rom_addr = window_size;
      default: rom_addr = '0;
    endcase
  end

  // control counters and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      scan_addr <= '0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      step      <= '0;
      wsum      <= '0;
      total     <= '0;
      used      <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.load) begin
        scan_addr <= '0;
        issuing   <= 1'b1;
        rd_vld    <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= issuing;
        if (issuing) begin
          if (scan_addr == AW'(ENTRIES - 1)) issuing <= 1'b0;
          else scan_addr <= scan_addr + 1'b1;
        end
      end
      if (cmd.decide) begin
        total <= total_dec;
        used  <= used_dec;
      end
      if (cmd.sum) begin
        step <= (step == SUM_LAST) ? 3'd0 : step + 1'b1;
        if (step == SUM_LAST) wsum <= acc[SW-1:0];
      end
    end
  end

  // search, decision, sum and result payload
  always_ff @(posedge clk) begin
    rom_q <= ROM[rom_addr];
    if (cmd.load) begin
      q_has_new <= has_new;
      q_has_old <= has_old;
      q_new_key <= new_key[KEY_BITS-1:0];
      q_old_key <= old_key[KEY_BITS-1:0];
      new_hit   <= 1'b0;
      old_hit   <= 1'b0;
      free_hit  <= 1'b0;
    end else if (cmd.scan) begin
      rd_idx <= scan_addr;
      if (rd_vld) begin
        if (rd_live && rd_key == q_new_key && !new_hit) begin
          new_hit <= 1'b1;
          new_idx <= rd_idx;
          new_cnt <= rd_cnt;
        end
        if (rd_live && rd_key == q_old_key && !old_hit) begin
          old_hit <= 1'b1;
          old_idx <= rd_idx;
          old_cnt <= rd_cnt;
        end
        if (!rd_live && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= rd_idx;
        end
      end
    end
    if (cmd.decide) begin
      wa_en  <= add_ok && !same;
      wa_idx <= a_idx;
      wa_cnt <= a_new;
      wr_en  <= rem_ok;
      wr_idx <= r_idx;
      wr_cnt <= r_cnt - 1'b1;
      ta[0]  <= add_ok ? a_new : '0;
      ta[1]  <= add_ok ? a_old : '0;
      ta[2]  <= rem_ok ? r_cnt - 1'b1 : '0;
      ta[3]  <= rem_ok ? r_cnt : '0;
      stat_q[STAT_FULL]   <= q_has_new && !add_ok;
      stat_q[STAT_ABSENT] <= q_has_old && !rem_ok;
      acc    <= LW'(wsum);
    end
    if (cmd.sum) begin
      case (step)
        3'd1:    acc  <= acc + rom_q;
        3'd2:    acc  <= acc - rom_q;
        3'd3:    acc  <= acc + rom_q;
        3'd4:    acc  <= acc - rom_q;
        3'd5:    lw_q <= rom_q;
        default: acc  <= acc;
      endcase
    end
    if (cmd.mul) prod <= total * lw_q;
    if (cmd.sub) begin
      nonpos <= quo <= PW'(wsum);
      diff   <= quo - PW'(wsum);
    end
    if (cmd.finish) begin
      if (window_size == '0 || nonpos) entropy <= '0;
      else if (quo > PW'(ENT_MAX)) entropy <= ENT_MAX;
      else entropy <= quo[ENT_W-1:0];
      distinct_keys <= DK_W'(used);
      status        <= stat_q;
    end
  end

  // shared divider for both truncating divisions by the window size
  swet_div #(
    .DW(PW),
    .VW(WIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? diff : prod),
    .divisor  (window_size),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign st.clear_done = clr_addr == AW'(ENTRIES - 1);
  assign st.scan_done  = rd_vld && !issuing;
  assign st.sum_done   = step == SUM_LAST;
  assign st.div_busy   = div_busy;

  // an empty table holds no items
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (used == '0) |-> (total == '0)) else $error("items counted with no entry in use");

  // no items means no weighted sum
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (total == '0) |-> (wsum == '0)) else $error("weighted sum left over with no items");

  // a new search never reports done on its first cycle
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !st.scan_done) else $error("search done right after load");

endmodule

// File: hw/rtl/swet_ctrl.sv
// sequencer for clearing, search, update and the entropy divisions
`timescale 1ns / 1ps
module swet_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output swet_pkg::swet_cmd_t cmd,
  input  swet_pkg::swet_st_t  st
);
  import swet_pkg::*;

  state_t state, state_next;

  // state register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (st.sum_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DSTART1;
      end
      ST_DSTART1: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV1;
      end
      ST_DIV1: begin
        if (!st.div_busy) state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_DSTART2;
      end
      ST_DSTART2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.div_sel = 1'b1;
        if (!st.div_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // an accepted beat goes straight into the search
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SCAN) else $error("accepted beat not searched");

  // a taken result with nothing behind it drops valid
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !cmd.finish |=> !out_valid) else $error("result beat repeated");

  // a finished item always shows up as a result
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finished result not presented");

endmodule

// File: hw/rtl/sliding_window_entropy_tracker.sv
// top level of the sliding-window entropy tracker
`timescale 1ns / 1ps
// Each input beat may add one key to the window and remove one key from it;
// one result beat follows with the window entropy (16 fractional bits), the
// number of table entries in use and a status (bit 0 addition refused because
// the table is full or the item count has reached ITEM_CAP, bit 1 leaving key
// not found). After reset the block clears the key table and accepts no beat
// while it does so. Each item then passes through a full linear search of the
// key table with one memory read per cycle, a decision step, an update of the
// weighted sum, a multiply step, a first division by window_size, a subtract
// step and a second division by window_size (both in a shared bit-serial
// divider: a start, a shift per quotient bit and a check that it is done),
// the output step and the idle step. The next beat is accepted while a
// finished result still waits in the output register; a result that is not
// taken holds the block in its output cycle. window_size is written through
// the APB port at byte address 0; the user must write it only while the block
// is idle, as the block itself does not enforce this. A value of zero gives
// entropy zero.
module sliding_window_entropy_tracker #(
  parameter int ENTRIES  = swet_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = swet_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          has_new,
  input  logic [swet_pkg::KEY_W-1:0]    new_key,
  input  logic                          has_old,
  input  logic [swet_pkg::KEY_W-1:0]    old_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swet_pkg::ENT_W-1:0]    entropy,
  output logic [swet_pkg::DK_W-1:0]     distinct_keys,
  output logic [swet_pkg::ST_W-1:0]     status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swet_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swet_pkg::*;

  swet_cmd_t        cmd;
  swet_st_t         st;
  logic [WIN_W-1:0] window_size;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
      window_size <= pwdata[WIN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size) : '0;

  swet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  swet_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .has_new       (has_new),
    .new_key       (new_key),
    .has_old       (has_old),
    .old_key       (old_key),
    .window_size   (window_size),
    .entropy       (entropy),
    .distinct_keys (distinct_keys),
    .status        (status)
  );

endmodule

// File: verif/sliding_window_entropy_tracker_test.sv
// testbench for the sliding-window entropy tracker
`timescale 1ns / 1ps
module sliding_window_entropy_tracker_test;
  import swet_pkg::*;

  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] STATUS_ABSENT  = 2'd2;
  localparam int TABLE_SIZE = ENTRIES_DEF;
  localparam int POOL_SIZE  = 300;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [ENT_W-1:0] entropy;
    logic [DK_W-1:0]  keys;
    logic [ST_W-1:0]  status;
  } window_report_t;

  typedef struct {
    logic            add;
    logic [KEY_W-1:0] add_key;
    logic            drop;
    logic [KEY_W-1:0] drop_key;
    bit              typed;
    window_report_t  report;
  } beat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic has_new = 1'b0;
  logic [KEY_W-1:0] new_key = '0;
  logic has_old = 1'b0;
  logic [KEY_W-1:0] old_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ENT_W-1:0] entropy;
  logic [DK_W-1:0] distinct_keys;
  logic [ST_W-1:0] status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sliding_window_entropy_tracker DUT (.*);

  always #5 clk = ~clk;

  // shadow of the key table and entropy sums
  longint unsigned clogc_tab [ROM_DEPTH];
  logic [KEY_W-1:0] shadow_key [TABLE_SIZE];
  int unsigned shadow_cnt [TABLE_SIZE];
  bit shadow_used [TABLE_SIZE];
  longint unsigned weight_sum;
  int unsigned item_count;
  int unsigned entries_used;
  int unsigned win_len;

  window_report_t pending_reports [$];
  int mismatches = 0;
  bit idling_on = 1'b1;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [KEY_W-1:0] window_keys [$];

  // c*log2(c) in fixed point, log2 by squaring the mantissa
  function automatic longint unsigned clogc_value(int unsigned c);
    longint unsigned y;
    longint unsigned frac;
    int k;
    if (c < 2) return 0;
    k = 0;
    while ((c >> (k + 1)) != 0) k++;
    y = (longint'(c) << 31) >> k;
    frac = 0;
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        frac |= 64'd1 << (29 - i);
        y >>= 1;
      end
    end
    return (longint'(c) * ((longint'(k) << 30) | frac)) >> (30 - FRAC_BITS);
  endfunction

  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (shadow_used[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  // apply one beat to the shadow table and compute the window entropy
  function automatic window_report_t track_window(logic add, logic [KEY_W-1:0] add_key,
                                                  logic drop, logic [KEY_W-1:0] drop_key);
    window_report_t r;
    int e;
    int f;
    int unsigned c;
    longint unsigned a;
    longint unsigned h;
    r.status = STATUS_OK;
    if (add) begin
      e = find_entry(add_key);
      f = -1;
      for (int i = TABLE_SIZE - 1; i >= 0; i--) if (!shadow_used[i]) f = i;
      if (item_count >= TABLE_SIZE || (e < 0 && f < 0)) begin
        r.status |= STATUS_REFUSED;
      end else if (e >= 0) begin
        c = shadow_cnt[e];
        weight_sum += clogc_tab[c + 1] - clogc_tab[c];
        shadow_cnt[e] = c + 1;
        item_count++;
      end else begin
        shadow_used[f] = 1'b1;
        shadow_key[f] = add_key;
        shadow_cnt[f] = 1;
        entries_used++;
        item_count++;
      end
    end
    if (drop) begin
      e = find_entry(drop_key);
      if (e < 0) begin
        r.status |= STATUS_ABSENT;
      end else begin
        c = shadow_cnt[e];
        weight_sum -= clogc_tab[c] - clogc_tab[c - 1];
        shadow_cnt[e] = c - 1;
        item_count--;
        if (c == 1) begin
          shadow_used[e] = 1'b0;
          entries_used--;
        end
      end
    end
    h = 0;
    if (win_len != 0) begin
      a = (longint'(item_count) * clogc_tab[win_len % ROM_DEPTH]) / longint'(win_len);
      if (a > weight_sum) begin
        h = (a - weight_sum) / longint'(win_len);
        if (h > longint'(ENT_MAX)) h = longint'(ENT_MAX);
      end
    end
    r.entropy = h[ENT_W-1:0];
    r.keys = entries_used[DK_W-1:0];
    return r;
  endfunction

  // hand one beat to the block, predict at acceptance
  task automatic send_beat(beat_row_t row);
    window_report_t r;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    has_new = row.add;
    new_key = row.add_key;
    has_old = row.drop;
    old_key = row.drop_key;
    do @(posedge clk); while (!in_ready);
    r = track_window(row.add, row.add_key, row.drop, row.drop_key);
    pending_reports.insert(pending_reports.size(), row.typed ? row.report : r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  // register write: setup phase, then access phase
  task automatic write_window(int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'(4 * int'(REG_WINDOW_SIZE));
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    win_len = value & 32'h1FF;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // result side: random stalls and compare against the oldest prediction
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    window_report_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: entropy %0d keys %0d status %0d",
                                       entropy, distinct_keys, status);
      end else begin
        w = pending_reports.pop_front();
        if (w.entropy !== entropy || w.keys !== distinct_keys || w.status !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: entropy %0d/%0d keys %0d/%0d status %0d/%0d (exp/act)",
                     w.entropy, entropy, w.keys, distinct_keys, w.status, status);
        end
      end
    end
  end

  // directed rows: typed results only where obvious
  beat_row_t directed [] = '{
    '{1'b0, 32'h0, 1'b1, 32'h5, 1'b1, '{20'd0, 9'd0, STATUS_ABSENT}},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b1, '{20'd2048, 9'd1, STATUS_OK}},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b1, 32'hA5A5_5A5A, 1'b1, 32'hA5A5_5A5A, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b1, 32'h5A5A_A5A5, 1'b1, 32'h0, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b0, 32'h0, 1'b1, 32'h1234_5678, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b1, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, '{20'd0, 9'd0, STATUS_OK}},
    '{1'b1, 32'h0000_0001, 1'b0, 32'h0, 1'b0, '{20'd0, 9'd0, STATUS_OK}}
  };

  int unsigned phase_window [] = '{256, 1, 0, 511, 2, 100, 256, 17, 200, 256};
  int unsigned phase_pool [] = '{4, 3, 8, 20, 2, 30, 300, 5, 60, 12};

  initial begin
    beat_row_t row;
    int pool_n;
    int unsigned depth;
    for (int c = 0; c < ROM_DEPTH; c++) clogc_tab[c] = clogc_value(c);
    for (int i = 0; i < TABLE_SIZE; i++) shadow_used[i] = 1'b0;
    weight_sum = 0;
    item_count = 0;
    entries_used = 0;
    win_len = 32'(WIN_RESET);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset window size
    wait_drained();
    foreach (directed[i]) send_beat(directed[i]);

    // random part, one phase for each entry of the window size list
    foreach (phase_window[p]) begin
      wait_drained();
      write_window(phase_window[p]);
      if (p == phase_window.size() - 1) idling_on = 1'b0;
      pool_n = phase_pool[p];
      depth = (win_len >= 1 && win_len <= TABLE_SIZE) ? win_len : TABLE_SIZE;
      for (int n = 0; n < 143; n++) begin
        row.typed = 1'b0;
        row.report = '{20'd0, 9'd0, STATUS_OK};
        if ($urandom_range(0, 9) == 0) begin
          // noise: random flags and keys, often absent
          row.add = 1'($urandom_range(0, 1));
          row.add_key = $urandom_range(0, 1) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
          row.drop = 1'($urandom_range(0, 1));
          row.drop_key = $urandom_range(0, 1) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
        end else begin
          // well-formed slide: oldest key leaves once the window is full
          row.add = 1'b1;
          row.add_key = key_pool[$urandom_range(0, pool_n - 1)];
          row.drop = window_keys.size() >= depth;
          row.drop_key = row.drop ? window_keys.pop_front() : $urandom;
          window_keys.insert(window_keys.size(), row.add_key);
        end
        send_beat(row);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule
